@@ rtl/mse_pkg.sv @@
// Package for the MIPS subset executor: constants, operation codes, payload
// structs and the controller/datapath command and status structs. No dependencies.
`default_nettype none
package mse_pkg;
    localparam int unsigned MEMORY_ROWS    = 16;
    localparam int unsigned MEMORY_COLUMNS = 8;
    localparam int unsigned PROGRAM_DEPTH  = 1024;
    localparam int unsigned MEM_DEPTH      = MEMORY_ROWS * MEMORY_COLUMNS;
    localparam int unsigned MEM_AW         = $clog2(MEM_DEPTH);
    localparam int unsigned PC_W           = 10;

    localparam logic [3:0] OP_ADDI = 4'd0;
    localparam logic [3:0] OP_ADD  = 4'd1;
    localparam logic [3:0] OP_SUB  = 4'd2;
    localparam logic [3:0] OP_SUBI = 4'd3;
    localparam logic [3:0] OP_MUL  = 4'd4;
    localparam logic [3:0] OP_DIV  = 4'd5;
    localparam logic [3:0] OP_BEQ  = 4'd6;
    localparam logic [3:0] OP_LW   = 4'd7;
    localparam logic [3:0] OP_SW   = 4'd8;
    localparam logic [3:0] OP_J    = 4'd9;

    localparam logic [2:0] CFG_REGDST   = 3'd0;
    localparam logic [2:0] CFG_ALUOP    = 3'd1;
    localparam logic [2:0] CFG_REGWRITE = 3'd2;
    localparam logic [2:0] CFG_BRANCH   = 3'd3;
    localparam logic [2:0] CFG_ALUSRC   = 3'd4;
    localparam logic [2:0] CFG_JUMP     = 3'd5;

    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_DIV0 = 2'd1;
    localparam logic [1:0] ERR_ADDR = 2'd2;

    typedef struct packed {
        logic [3:0]         operation;
        logic [4:0]         first_reg;
        logic [4:0]         second_reg;
        logic [4:0]         third_reg;
        logic signed [31:0] immediate;
        logic [9:0]         target_index;
    } in_item_t;

    typedef struct packed {
        logic [9:0]         next_pc;
        logic               suppressed;
        logic               reg_written;
        logic [4:0]         write_index;
        logic signed [31:0] write_value;
        logic               memory_written;
        logic [1:0]         error_code;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // capture the item and read operands
        logic mem_rd;   // start the memory read / address check
        logic div_go;   // start the divider
        logic div_step; // one divider iteration
        logic finish;   // commit results and load the output register
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_div;
        logic is_mem;
        logic div_done;
    } sts_t;
endpackage
`default_nettype wire

@@ rtl/mips_subset_executor_with_stuck_faults.sv @@
// Top level of the MIPS subset executor with stuck-at control-line faults.
// Depends on mse_pkg, mse_ctrl and mse_dp.
`default_nettype none
// The block executes one decoded instruction per input transfer and returns
// exactly one result transfer for it. Both channels use valid/ready.
// The configuration port writes one stuck-at bit per register index
// (0 RegDst, 1 ALUOp, 2 RegWrite, 3 Branch, 4 ALUSrc, 5 Jump); bit 0 of
// cfg_data is taken, indexes above 5 are ignored.
// An input transfer goes through decode and finish for most instructions,
// through a registered memory read for lw and sw, and through the
// radix-2 divider, one quotient bit a cycle, for a div with a nonzero divisor.
// One instruction is in flight at a time, so a new item is taken only once
// the last one has finished and the controller is back in idle.
// Results sit in an output register; while the receiver stalls, the block
// holds the result and will not start finishing the next item until that
// register is free, though a new input transfer is taken once idle.
// Reset clears the PC, the fault bits and the register file; the data memory
// reads as zero after reset through per-word valid bits, with no clearing
// pass.
module mips_subset_executor_with_stuck_faults (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire mse_pkg::in_item_t in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output mse_pkg::out_item_t     out_data,
    input  wire logic              cfg_we,
    input  wire logic [2:0]        cfg_index,
    input  wire logic              cfg_data
);
    import mse_pkg::*;

    cmd_t cmd;
    sts_t sts;
    logic busy;
    logic in_fire;
    logic out_free;
    logic [5:0] stuck_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stuck_reg <= '0;
        else if (cfg_we && cfg_index <= CFG_JUMP)
            stuck_reg[cfg_index] <= cfg_data;
    end

    assign in_ready = !busy;
    assign in_fire  = in_valid && in_ready;
    // The output register can be refilled when empty or being drained.
    assign out_free = !out_valid || out_ready;

    mse_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .out_free (out_free),
        .sts      (sts),
        .cmd      (cmd),
        .busy     (busy)
    );

    mse_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_item   (in_data),
        .stuck     (stuck_reg),
        .out_pop   (out_ready),
        .sts       (sts),
        .out_valid (out_valid),
        .out_item  (out_data)
    );
endmodule
`default_nettype wire

@@ rtl/mse_ctrl.sv @@
// Controller state machine of the MIPS subset executor.
// Depends on mse_pkg.
`default_nettype none
module mse_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_fire,
    input  wire logic          out_free,
    input  wire mse_pkg::sts_t sts,
    output mse_pkg::cmd_t      cmd,
    output logic               busy
);
    import mse_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_DEC  = 6'b000010,
        S_MEM  = 6'b000100,
        S_DIV  = 6'b001000,
        S_DIVW = 6'b010000,
        S_FIN  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                if (sts.is_div)
                begin
                    cmd.div_go = 1'b1;
                    state_next = S_DIV;
                end
                else if (sts.is_mem)
                begin
                    cmd.mem_rd = 1'b1;
                    state_next = S_MEM;
                end
                else
                    state_next = S_FIN;
            end
            S_MEM: state_next = S_FIN;
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_done)
                    state_next = S_DIVW;
            end
            S_DIVW: state_next = S_FIN;
            S_FIN:
            begin
                if (out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign busy = (state_reg != S_IDLE);
endmodule
`default_nettype wire

@@ rtl/mse_dp.sv @@
// Datapath of the MIPS subset executor: register file, data memory, ALU,
// iterative divider, PC and output register. Depends on mse_pkg.
`default_nettype none
module mse_dp (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire mse_pkg::cmd_t    cmd,
    input  wire mse_pkg::in_item_t in_item,
    input  wire logic [5:0]       stuck,
    input  wire logic             out_pop,
    output mse_pkg::sts_t         sts,
    output logic                  out_valid,
    output mse_pkg::out_item_t    out_item
);
    import mse_pkg::*;

    logic [31:0] rf_reg [32];
    logic [31:0] mem_reg [MEM_DEPTH];
    logic [MEM_DEPTH-1:0] mem_vld_reg;
    logic [PC_W-1:0] pc_reg;

    in_item_t    item_reg;
    logic [31:0] a_reg, b_reg, c_reg;
    logic [31:0] mem_q_reg;
    logic        mem_q_vld_reg;
    logic [MEM_AW-1:0] slot_reg;
    logic        addr_ok_reg;

    // Divider: restoring, one quotient bit per cycle on magnitudes.
    logic [31:0] dq_reg, drem_reg, dden_reg;
    logic [5:0]  dcnt_reg;
    logic        dneg_reg;
    logic [32:0] dtrial;

    out_item_t   out_reg;
    logic        outv_reg;

    logic alu_stuck;
    logic op_alu, op_mem;
    logic signed [32:0] row;
    logic signed [31:0] col;
    logic [31:0] a_abs, b_abs;
    logic [31:0] res;
    out_item_t   o;
    logic [31:0] quo;

    assign alu_stuck = stuck[CFG_REGDST] | stuck[CFG_ALUOP] | stuck[CFG_REGWRITE];
    assign op_alu    = (item_reg.operation <= OP_DIV);
    assign op_mem    = (item_reg.operation == OP_LW) || (item_reg.operation == OP_SW);

    assign sts.is_div   = (item_reg.operation == OP_DIV) && !alu_stuck && (b_reg != 32'd0);
    assign sts.is_mem   = op_mem && !(stuck[CFG_BRANCH] | stuck[CFG_ALUSRC]);
    assign sts.div_done = (dcnt_reg == 6'd0);

    assign row   = {a_reg[31], a_reg};
    assign col   = item_reg.immediate / 4;
    assign a_abs = a_reg[31] ? (32'd0 - a_reg) : a_reg;
    assign b_abs = b_reg[31] ? (32'd0 - b_reg) : b_reg;
    assign dtrial = {drem_reg, dden_reg[31]} - {1'b0, b_abs};
    assign quo   = dneg_reg ? (32'd0 - dq_reg) : dq_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= in_item;
            a_reg    <= rf_reg[in_item.second_reg];
            b_reg    <= rf_reg[in_item.third_reg];
            c_reg    <= rf_reg[in_item.first_reg];
        end
        if (cmd.mem_rd)
        begin
            addr_ok_reg <= (row >= 0) && (row < MEMORY_ROWS)
                        && (col >= 0) && (col < MEMORY_COLUMNS);
            slot_reg <= MEM_AW'(a_reg * MEMORY_COLUMNS + 32'(col));
        end
        if (cmd.div_go)
        begin
            dq_reg   <= '0;
            drem_reg <= '0;
            dden_reg <= a_abs;
            dcnt_reg <= 6'd32;
            dneg_reg <= a_reg[31] ^ b_reg[31];
        end
        else if (cmd.div_step && dcnt_reg != 6'd0)
        begin
            dden_reg <= {dden_reg[30:0], 1'b0};
            dcnt_reg <= dcnt_reg - 6'd1;
            if (!dtrial[32])
            begin
                drem_reg <= dtrial[31:0];
                dq_reg   <= {dq_reg[30:0], 1'b1};
            end
            else
            begin
                drem_reg <= {drem_reg[30:0], dden_reg[31]};
                dq_reg   <= {dq_reg[30:0], 1'b0};
            end
        end
    end

    // Data memory: registered read, one write port.
    always_ff @(posedge clk)
    begin
        mem_q_reg <= mem_reg[slot_reg];
        if (cmd.finish && o.memory_written)
            mem_reg[slot_reg] <= c_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 32; i++)
                rf_reg[i] <= '0;
            mem_vld_reg   <= '0;
            mem_q_vld_reg <= 1'b0;
            pc_reg        <= '0;
            outv_reg      <= 1'b0;
        end
        else
        begin
            mem_q_vld_reg <= mem_vld_reg[slot_reg];
            if (cmd.finish)
            begin
                pc_reg   <= o.next_pc;
                outv_reg <= 1'b1;
                if (o.memory_written)
                    mem_vld_reg[slot_reg] <= 1'b1;
                if (o.reg_written)
                    rf_reg[o.write_index] <= o.write_value;
            end
            else if (out_pop)
                outv_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
            out_reg <= o;
    end

    always_comb
    begin
        o         = '0;
        o.next_pc = pc_reg + PC_W'(1);
        res       = '0;
        case (item_reg.operation)
            OP_ADDI: res = a_reg + item_reg.immediate;
            OP_ADD:  res = a_reg + b_reg;
            OP_SUB:  res = a_reg - b_reg;
            OP_SUBI: res = a_reg - item_reg.immediate;
            OP_MUL:  res = a_reg * b_reg;
            default: res = quo;
        endcase
        if (op_alu)
        begin
            if (alu_stuck)
                o.suppressed = 1'b1;
            else if (item_reg.operation == OP_DIV && b_reg == 32'd0)
                o.error_code = ERR_DIV0;
            else
            begin
                o.reg_written = 1'b1;
                o.write_index = item_reg.first_reg;
                o.write_value = res;
            end
        end
        else if (item_reg.operation == OP_BEQ)
        begin
            if (stuck[CFG_BRANCH] | stuck[CFG_ALUOP])
                o.suppressed = 1'b1;
            else if (c_reg == a_reg)
                o.next_pc = item_reg.target_index;
        end
        else if (op_mem)
        begin
            if (stuck[CFG_BRANCH] | stuck[CFG_ALUSRC])
                o.suppressed = 1'b1;
            else if (!addr_ok_reg)
                o.error_code = ERR_ADDR;
            else if (item_reg.operation == OP_LW)
            begin
                o.reg_written = 1'b1;
                o.write_index = item_reg.first_reg;
                o.write_value = mem_q_vld_reg ? mem_q_reg : 32'd0;
            end
            else
            begin
                o.memory_written = 1'b1;
                o.write_value    = c_reg;
            end
        end
        else if (item_reg.operation == OP_J)
        begin
            if (stuck[CFG_JUMP])
                o.suppressed = 1'b1;
            else
                o.next_pc = item_reg.target_index;
        end
    end

    assign out_valid = outv_reg;
    assign out_item  = out_reg;
endmodule
`default_nettype wire

@@ test/mips_subset_executor_with_stuck_faults_tb.sv @@
// Testbench for the MIPS subset executor with stuck-at control-line faults.
// Depends on mse_pkg and the RTL top level mips_subset_executor_with_stuck_faults.
// A scoreboard class predicts every result; plain tasks drive input and config.
`default_nettype none

module mips_subset_executor_with_stuck_faults_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mse_pkg::*;

    // Operation code with no package name: a label line that does nothing.
    localparam logic [3:0] OP_LABEL = 4'd10;
    // Generous cycle limit for the whole run.
    localparam int unsigned CYCLE_LIMIT = 600000;
    // Cycles to let pass before a configuration write: the longest latency
    // (a division) with some margin.
    localparam int unsigned SETTLE_CYCLES = 48;

    // The scoreboard holds its own copy of the architectural state and the
    // stuck-at bits. note_input() runs the instruction on that copy and
    // queues the expected result; check_result() compares against the oldest.
    class exec_scoreboard;
        logic [31:0] regs [32];
        logic [31:0] dmem [MEM_DEPTH];
        logic [9:0]  pc;
        logic        stuck [6];
        out_item_t   pending [$];
        int unsigned errors;
        int unsigned results_seen;

        function void clear();
            foreach (regs[i]) regs[i] = '0;
            foreach (dmem[i]) dmem[i] = '0;
            foreach (stuck[i]) stuck[i] = 1'b0;
            pc = '0;
            errors = 0;
            results_seen = 0;
        endfunction

        function void set_fault(logic [2:0] idx, logic val);
            if (idx <= CFG_JUMP)
                stuck[idx] = val;
        endfunction

        function void note_input(in_item_t it);
            out_item_t   r;
            logic [31:0] a;
            logic [31:0] b;
            logic [31:0] res;
            logic        alu_off;
            int          row;
            int          col;
            int          slot;
            a = regs[it.second_reg];
            b = regs[it.third_reg];
            r = '0;
            r.next_pc = pc + 10'd1;
            alu_off = stuck[CFG_REGDST] | stuck[CFG_ALUOP] | stuck[CFG_REGWRITE];
            if (it.operation <= OP_DIV) begin
                if (alu_off) begin
                    r.suppressed = 1'b1;
                end else if (it.operation == OP_DIV && b == 32'd0) begin
                    r.error_code = ERR_DIV0;
                end else begin
                    case (it.operation)
                        OP_ADDI: res = a + it.immediate;
                        OP_ADD:  res = a + b;
                        OP_SUB:  res = a - b;
                        OP_SUBI: res = a - it.immediate;
                        OP_MUL:  res = a * b;
                        default:
                        begin
                            // The most negative value over minus one wraps.
                            if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF)
                                res = 32'h8000_0000;
                            else
                                res = $signed(a) / $signed(b);
                        end
                    endcase
                    regs[it.first_reg] = res;
                    r.reg_written = 1'b1;
                    r.write_index = it.first_reg;
                    r.write_value = res;
                end
            end else if (it.operation == OP_BEQ) begin
                if (stuck[CFG_BRANCH] | stuck[CFG_ALUOP])
                    r.suppressed = 1'b1;
                else if (regs[it.first_reg] == a)
                    r.next_pc = it.target_index;
            end else if (it.operation == OP_LW || it.operation == OP_SW) begin
                row = $signed(a);
                col = $signed(it.immediate) / 4;
                if (stuck[CFG_BRANCH] | stuck[CFG_ALUSRC]) begin
                    r.suppressed = 1'b1;
                end else if (row < 0 || row >= MEMORY_ROWS || col < 0
                             || col >= MEMORY_COLUMNS) begin
                    r.error_code = ERR_ADDR;
                end else begin
                    slot = row * MEMORY_COLUMNS + col;
                    if (it.operation == OP_LW) begin
                        regs[it.first_reg] = dmem[slot];
                        r.reg_written = 1'b1;
                        r.write_index = it.first_reg;
                        r.write_value = dmem[slot];
                    end else begin
                        dmem[slot] = regs[it.first_reg];
                        r.memory_written = 1'b1;
                        r.write_value = regs[it.first_reg];
                    end
                end
            end else if (it.operation == OP_J) begin
                if (stuck[CFG_JUMP])
                    r.suppressed = 1'b1;
                else
                    r.next_pc = it.target_index;
            end
            pc = r.next_pc;
            pending.push_back(r);
        endfunction

        function void check_result(out_item_t got);
            out_item_t exp;
            results_seen++;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %p", $time, got);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.next_pc !== exp.next_pc) begin
                $display("%0t: next_pc expected %0d actual %0d", $time, exp.next_pc,
                         got.next_pc);
                errors++;
            end
            if (got.suppressed !== exp.suppressed) begin
                $display("%0t: suppressed expected %0b actual %0b", $time,
                         exp.suppressed, got.suppressed);
                errors++;
            end
            if (got.reg_written !== exp.reg_written) begin
                $display("%0t: reg_written expected %0b actual %0b", $time,
                         exp.reg_written, got.reg_written);
                errors++;
            end
            if (got.write_index !== exp.write_index) begin
                $display("%0t: write_index expected %0d actual %0d", $time,
                         exp.write_index, got.write_index);
                errors++;
            end
            if (got.write_value !== exp.write_value) begin
                $display("%0t: write_value expected %h actual %h", $time,
                         exp.write_value, got.write_value);
                errors++;
            end
            if (got.memory_written !== exp.memory_written) begin
                $display("%0t: memory_written expected %0b actual %0b", $time,
                         exp.memory_written, got.memory_written);
                errors++;
            end
            if (got.error_code !== exp.error_code) begin
                $display("%0t: error_code expected %0d actual %0d", $time,
                         exp.error_code, got.error_code);
                errors++;
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    in_item_t   in_data;
    logic       out_valid;
    logic       out_ready;
    out_item_t  out_data;
    logic       cfg_we;
    logic [2:0] cfg_index;
    logic       cfg_data;

    exec_scoreboard sb;
    bit             idle_on;
    int unsigned    cycles;
    int unsigned    sent;
    int unsigned    phases;

    mips_subset_executor_with_stuck_faults u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // Watchdog: if the run has not ended by the limit, something hung.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Receiver side. The ready line stalls in random bursts while idling is
    // enabled. Every result transfer is checked at the edge that takes it;
    // values sampled here are the ones that were stable before the edge.
    int unsigned stall_left;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_ready  <= 1'b0;
            stall_left <= 0;
        end else begin
            if (out_valid && out_ready)
                sb.check_result(out_data);
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                out_ready  <= 1'b0;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                stall_left <= $urandom_range(0, 15);
                out_ready  <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    function automatic in_item_t make_item(logic [3:0] op, logic [4:0] r1, logic [4:0] r2,
                                           logic [4:0] r3, logic [31:0] imm,
                                           logic [9:0] tgt);
        in_item_t it;
        it.operation    = op;
        it.first_reg    = r1;
        it.second_reg   = r2;
        it.third_reg    = r3;
        it.immediate    = imm;
        it.target_index = tgt;
        return it;
    endfunction

    // Sends one instruction. Valid stays high between back-to-back items;
    // it only drops when a random gap is taken before the next one. Ready is
    // looked at on the falling edge, where it already shows whether the
    // coming rising edge takes the item.
    task automatic send_item(in_item_t it);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(negedge clk);
        while (!in_ready)
            @(negedge clk);
        @(posedge clk);
        sb.note_input(it);
        sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
    endtask

    // Writes all six fault bits. Only done with the block idle.
    task automatic write_faults(logic [5:0] mask);
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        for (int i = CFG_REGDST; i <= CFG_JUMP; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= i[2:0];
            cfg_data  <= mask[i];
            @(posedge clk);
            sb.set_fault(i[2:0], mask[i]);
        end
        cfg_we <= 1'b0;
        phases++;
    endtask

    // Loads a register with an exact value through addi on itself, unless an ALU fault bit suppresses the addi.
    task automatic load_reg(logic [4:0] r, logic [31:0] val);
        send_item(make_item(OP_ADDI, r, r, 5'd0, val - sb.regs[r], 10'd0));
    endtask

    // A memory access preceded by setting its base register: mostly legal
    // rows and columns, sometimes just outside, sometimes negative offsets.
    task automatic mem_sequence();
        logic [4:0]  base;
        logic [31:0] imm;
        int          row;
        base = 5'($urandom_range(0, 31));
        row  = ($urandom_range(0, 9) == 0) ? (($urandom_range(0, 1) == 1) ? -1 :
               MEMORY_ROWS) : $urandom_range(0, MEMORY_ROWS - 1);
        load_reg(base, row);
        case ($urandom_range(0, 9))
            0: imm = $urandom;
            1: imm = -$urandom_range(1, 8);
            2: imm = MEMORY_COLUMNS * 4 + $urandom_range(0, 3);
            default: imm = $urandom_range(0, MEMORY_COLUMNS * 4 - 1);
        endcase
        send_item(make_item(($urandom_range(0, 1) == 1) ? OP_SW : OP_LW,
                            5'($urandom_range(0, 31)), base, 5'($urandom_range(0, 31)),
                            imm, 10'($urandom_range(0, 1023))));
    endtask

    // Random instruction: small immediates mostly, so values stay useful as
    // addresses and divisors, and full-width values now and then.
    task automatic random_item();
        in_item_t    it;
        logic [31:0] imm;
        imm = ($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(0, 40) - 20;
        it = make_item(4'($urandom_range(0, 15)), 5'($urandom_range(0, 31)),
                       5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)), imm,
                       10'($urandom_range(0, 1023)));
        // In half of the cases beq compares a register with itself so the branch is taken.
        if (it.operation == OP_BEQ && $urandom_range(0, 1) == 1)
            it.second_reg = it.first_reg;
        send_item(it);
    endtask

    task automatic random_phase(int unsigned count, bit pause_midway);
        int unsigned start;
        start = sent;
        while (sent - start < count) begin
            if (pause_midway && sent - start == count / 2)
                drain();
            case ($urandom_range(0, 9))
                0, 1, 2: mem_sequence();
                3:
                begin
                    // Division with a zero divisor or the wrapping corner.
                    if ($urandom_range(0, 1) == 1) begin
                        load_reg(5'd30, 32'h8000_0000);
                        load_reg(5'd31, 32'hFFFF_FFFF);
                    end else begin
                        load_reg(5'd31, 32'd0);
                    end
                    send_item(make_item(OP_DIV, 5'($urandom_range(0, 29)), 5'd30, 5'd31,
                                        $urandom, 10'($urandom_range(0, 1023))));
                end
                default: random_item();
            endcase
        end
    endtask

    initial
    begin
        sb = new();
        sb.clear();
        idle_on   = 1'b1;
        cycles    = 0;
        sent      = 0;
        phases    = 0;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part with every fault bit clear: arithmetic extremes,
        // wrapping, both division corners, branches, jumps, label lines,
        // unused codes, the corners of memory and a write to register zero.
        send_item(make_item(OP_ADDI, 5'd1, 5'd0, 5'd0, 32'h7FFF_FFFF, 10'd0));
        send_item(make_item(OP_ADDI, 5'd2, 5'd0, 5'd0, 32'h8000_0000, 10'd0));
        send_item(make_item(OP_SUBI, 5'd3, 5'd0, 5'd0, 32'd1, 10'd0));
        send_item(make_item(OP_ADD, 5'd4, 5'd1, 5'd1, 32'd0, 10'd0));
        send_item(make_item(OP_SUB, 5'd5, 5'd2, 5'd1, 32'd0, 10'd0));
        send_item(make_item(OP_SUBI, 5'd6, 5'd2, 5'd0, 32'd1, 10'd0));
        send_item(make_item(OP_MUL, 5'd7, 5'd1, 5'd1, 32'd0, 10'd0));
        send_item(make_item(OP_DIV, 5'd8, 5'd2, 5'd3, 32'd0, 10'd0));
        send_item(make_item(OP_DIV, 5'd9, 5'd1, 5'd10, 32'd0, 10'd0));
        send_item(make_item(OP_DIV, 5'd11, 5'd3, 5'd7, 32'd0, 10'd0));
        send_item(make_item(OP_DIV, 5'd12, 5'd2, 5'd1, 32'd0, 10'd0));
        send_item(make_item(OP_BEQ, 5'd10, 5'd10, 5'd0, 32'd0, 10'h3FF));
        send_item(make_item(OP_ADDI, 5'd13, 5'd0, 5'd0, 32'd0, 10'd0));
        send_item(make_item(OP_BEQ, 5'd1, 5'd2, 5'd0, 32'd0, 10'd5));
        send_item(make_item(OP_J, 5'd0, 5'd0, 5'd0, 32'd0, 10'd0));
        send_item(make_item(OP_LABEL, 5'd31, 5'd31, 5'd31, 32'hFFFF_FFFF, 10'h3FF));
        send_item(make_item(4'd15, 5'd31, 5'd31, 5'd31, 32'hFFFF_FFFF, 10'h3FF));
        send_item(make_item(OP_SW, 5'd1, 5'd10, 5'd0, 32'd28, 10'd0));
        send_item(make_item(OP_LW, 5'd14, 5'd10, 5'd0, 32'd28, 10'd0));
        send_item(make_item(OP_LW, 5'd15, 5'd10, 5'd0, 32'hFFFF_FFFD, 10'd0));
        send_item(make_item(OP_SW, 5'd1, 5'd10, 5'd0, 32'd32, 10'd0));
        send_item(make_item(OP_LW, 5'd16, 5'd3, 5'd0, 32'd0, 10'd0));
        send_item(make_item(OP_ADDI, 5'd0, 5'd0, 5'd0, 32'd5, 10'd0));

        // Random phases under several fault settings, all set and all clear
        // among them. One phase pauses the sender until the block is empty.
        random_phase(120, 1'b1);
        write_faults(6'b111111);
        random_phase(60, 1'b0);
        write_faults(6'b000001);
        random_phase(70, 1'b0);
        write_faults(6'b000010);
        random_phase(70, 1'b0);
        write_faults(6'b000100);
        random_phase(70, 1'b0);
        write_faults(6'b001000);
        random_phase(70, 1'b0);
        write_faults(6'b010000);
        random_phase(70, 1'b0);
        write_faults(6'b100000);
        random_phase(70, 1'b0);
        write_faults(6'($urandom_range(0, 63)));
        random_phase(70, 1'b0);
        write_faults(6'b000000);
        random_phase(80, 1'b0);

        // Last stretch without idling on either side.
        idle_on = 1'b0;
        random_phase(60, 1'b0);

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.pending.size() != 0) begin
            $display("%0d results never arrived", sb.pending.size());
            sb.errors++;
        end
        $display("Ran %0d instructions and checked %0d results across %0d fault settings",
                 sent, sb.results_seen, phases + 1);
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

`default_nettype wire
